// File: src/obprs_pkg.sv
// Package for the one-bit packed record store.
// Holds sizing constants, the operation code and the queue entry type.
// No dependencies.
`default_nettype none
package obprs_pkg;

	localparam int WORD_BITS         = 32;
	localparam int STORE_WORDS       = 1024;
	localparam int MAX_RECORD_BITS   = 64;
	localparam int LEN_W             = 7;
	localparam int IDX_W             = 15;
	localparam int RECORD_LENGTH_RST = 32;
	localparam int BIT_W             = $clog2(WORD_BITS);
	localparam int POS_W             = IDX_W + LEN_W;
	localparam int AW                = $clog2(STORE_WORDS);
	localparam int WC_W              = $clog2(STORE_WORDS + 1);
	localparam int TOT_W             = WC_W + BIT_W;
	localparam int CMP_W             = ((POS_W > TOT_W) ? POS_W : TOT_W) + 1;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_EXPAND = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             bit_value;
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] start;
	} entry_t;

endpackage
`default_nettype wire

// File: src/obprs_front.sv
// Front end: accepts requests, holds the record length register, clamps the
// length and computes the record start position. Depends on obprs_pkg.
`default_nettype none
module obprs_front import obprs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             operation,
	input  wire logic             bit_value,
	input  wire logic [IDX_W-1:0] record_index,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [LEN_W-1:0] cfg_data,
	output logic                  push,
	output entry_t                push_entry,
	input  wire logic             q_full
);

	logic [LEN_W-1:0] record_length_q;
	logic [LEN_W-1:0] len_eff;
	logic [POS_W-1:0] start;
	logic             accept;
	logic             valid_s1;
	entry_t           entry_s1;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (record_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (record_length_q > LEN_W'(MAX_RECORD_BITS)) begin
			len_eff = LEN_W'(MAX_RECORD_BITS);
		end else begin
			len_eff = record_length_q;
		end
	end

	assign start    = POS_W'(record_index) * POS_W'(len_eff);
	assign push     = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q <= LEN_W'(RECORD_LENGTH_RST);
			valid_s1        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				record_length_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.op        <= op_t'(operation);
			entry_s1.bit_value <= bit_value;
			entry_s1.len       <= len_eff;
			entry_s1.start     <= start;
		end
	end

endmodule
`default_nettype wire

// File: src/obprs_queue.sv
// Short request queue between front and back ends.
// Depends on obprs_pkg for the entry type and depth.
`default_nettype none
module obprs_queue import obprs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        q_full,
	output logic        q_valid,
	output entry_t      q_entry,
	input  wire logic   pop
);

	entry_t              slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_entry = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

// File: src/obprs_back.sv
// Back end: packs appended bits, owns the word memory and streams records.
// Depends on obprs_pkg.
`default_nettype none
module obprs_back import obprs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire entry_t q_entry,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic        out_bit,
	output logic        last,
	output logic        out_of_range,
	output logic        overflowed
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	logic [WORD_BITS-1:0] mem [STORE_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [WORD_BITS-1:0] partial_word_q;
	logic [WORD_BITS-1:0] pw_next;
	logic [BIT_W-1:0]     partial_count_q;
	logic [WC_W-1:0]      word_count_q;
	logic                 overflow_q;
	state_t               state_q, state_n;
	logic [POS_W-1:0]     pos_q, pos_n;
	logic [LEN_W-1:0]     cnt_q, cnt_n;
	logic                 out_valid_q, out_bit_q, last_q, oor_q, ovf_out_q;
	logic                 load_out, ob_n, last_n, oor_n;
	logic                 app, mem_we, fetch, out_free;
	logic [TOT_W-1:0]     full_bits;
	logic [CMP_W-1:0]     total_bits, rec_end, pos_off;
	logic                 expand_oor, start_in_mem, pos_in_mem, next_in_mem, cur_bit;
	logic [BIT_W-1:0]     psh;

	assign out_free     = !out_valid_q || !out_stall;
	assign full_bits    = {word_count_q, BIT_W'(0)};
	assign total_bits   = CMP_W'(full_bits) + CMP_W'(partial_count_q);
	assign rec_end      = CMP_W'(q_entry.start) + CMP_W'(q_entry.len);
	assign expand_oor   = rec_end > total_bits;
	assign start_in_mem = CMP_W'(q_entry.start) < CMP_W'(full_bits);
	assign pos_in_mem   = CMP_W'(pos_q) < CMP_W'(full_bits);
	assign next_in_mem  = (CMP_W'(pos_q) + CMP_W'(1)) < CMP_W'(full_bits);
	assign pos_off      = CMP_W'(pos_q) - CMP_W'(full_bits);
	assign psh          = partial_count_q - BIT_W'(1) - pos_off[BIT_W-1:0];
	assign cur_bit      = pos_in_mem ? rd_data_q[~pos_q[BIT_W-1:0]] : partial_word_q[psh];
	assign pw_next      = {partial_word_q[WORD_BITS-2:0], q_entry.bit_value};
	assign mem_we       = app && (partial_count_q == BIT_W'(WORD_BITS - 1))
	                      && (word_count_q < WC_W'(STORE_WORDS));

	always_comb begin
		state_n  = state_q;
		pos_n    = pos_q;
		cnt_n    = cnt_q;
		pop      = 1'b0;
		app      = 1'b0;
		fetch    = 1'b0;
		load_out = 1'b0;
		ob_n     = 1'b0;
		last_n   = 1'b0;
		oor_n    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_entry.op == OP_APPEND) begin
						pop = 1'b1;
						app = 1'b1;
					end else if (expand_oor) begin
						if (out_free) begin
							pop      = 1'b1;
							load_out = 1'b1;
							last_n   = 1'b1;
							oor_n    = 1'b1;
						end
					end else begin
						pop     = 1'b1;
						pos_n   = q_entry.start;
						cnt_n   = q_entry.len;
						state_n = start_in_mem ? ST_FETCH : ST_EMIT;
					end
				end
			end
			ST_FETCH: begin
				fetch   = 1'b1;
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					ob_n     = cur_bit;
					last_n   = cnt_q == LEN_W'(1);
					pos_n    = pos_q + POS_W'(1);
					cnt_n    = cnt_q - LEN_W'(1);
					if (cnt_q == LEN_W'(1)) begin
						state_n = ST_IDLE;
					end else if (pos_q[BIT_W-1:0] == BIT_W'(WORD_BITS - 1) && next_in_mem) begin
						state_n = ST_FETCH;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			partial_count_q <= '0;
			partial_word_q  <= '0;
			word_count_q    <= '0;
			overflow_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (app) begin
				if (partial_count_q == BIT_W'(WORD_BITS - 1)) begin
					partial_word_q  <= '0;
					partial_count_q <= '0;
					if (word_count_q < WC_W'(STORE_WORDS)) begin
						word_count_q <= word_count_q + WC_W'(1);
					end else begin
						overflow_q <= 1'b1;
					end
				end else begin
					partial_word_q  <= pw_next;
					partial_count_q <= partial_count_q + BIT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_n;
		if (load_out) begin
			out_bit_q <= ob_n;
			last_q    <= last_n;
			oor_q     <= oor_n;
			ovf_out_q <= overflow_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[word_count_q[AW-1:0]] <= pw_next;
		end
		if (fetch) begin
			rd_data_q <= mem[pos_q[BIT_W +: AW]];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_bit      = out_bit_q;
	assign last         = last_q;
	assign out_of_range = oor_q;
	assign overflowed   = ovf_out_q;

`ifndef SYNTHESIS
	a_word_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= WC_W'(STORE_WORDS))
		else $error("word count past memory size");
	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");
	a_busy_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt_q != '0))
		else $error("record streaming with no bits left");
	a_fetch_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_EMIT))
		else $error("fetch not followed by emit");
`endif

endmodule
`default_nettype wire

// File: src/one_bit_packed_record_store_top.sv
// Path: a request is registered in the front stage, queued, then popped by the back end;
// an append goes into the packed state, an out-of-range expand to the output register,
// an in-range one via ST_EMIT, or ST_FETCH then ST_EMIT if it starts in the word memory.
// Throughput: one append per cycle while the queue is not full and the back end is idle;
// a record streams one bit per cycle, save in ST_FETCH per 32-bit word and under out_stall.
// Reset clears counts, flag and queue and sets record_length to 32; memory is not reset.
`default_nettype none
module one_bit_packed_record_store_top import obprs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             operation,
	input  wire logic             bit_value,
	input  wire logic [IDX_W-1:0] record_index,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [LEN_W-1:0] cfg_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  out_bit,
	output logic                  last,
	output logic                  out_of_range,
	output logic                  overflowed
);

	logic   push;
	logic   q_full;
	logic   q_valid;
	logic   pop;
	entry_t push_entry;
	entry_t q_entry;

	obprs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.bit_value    (bit_value),
		.record_index (record_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.push_entry   (push_entry),
		.q_full       (q_full)
	);

	obprs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.pop        (pop)
	);

	obprs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_bit      (out_bit),
		.last         (last),
		.out_of_range (out_of_range),
		.overflowed   (overflowed)
	);

endmodule
`default_nettype wire
